// ===== rtl/pob_pkg.sv =====
// shared types and constants of the price-time order book
package pob_pkg;

  localparam int unsigned IdW     = 16;
  localparam int unsigned PriceW  = 31;
  localparam int unsigned QtyW    = 24;
  localparam int unsigned LvlQtyW = 29;
  localparam int unsigned SmallW  = 6;
  localparam int unsigned InDataW = 72;
  localparam int unsigned InUserW = 3;
  localparam int unsigned OutDataW = 80;
  localparam int unsigned OutUserW = 2;
  localparam int unsigned MaxResults = 32;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_DUMP   = 2'd2,
    OP_COUNT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef struct packed {
    op_e               op;
    logic              side;
    logic [IdW-1:0]    id;
    logic [PriceW-1:0] price;
    logic [QtyW-1:0]   qty;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic [PriceW-1:0]  price;
    logic [LvlQtyW-1:0] qty;
    logic [SmallW-1:0]  orders;
    logic [SmallW-1:0]  bid_lvls;
    logic [SmallW-1:0]  ask_lvls;
    logic               last;
  } result_t;

  // saturate a small count at 63
  function automatic logic [SmallW-1:0] sat_small(input logic [SmallW:0] v);
    return v[SmallW] ? {SmallW{1'b1}} : v[SmallW-1:0];
  endfunction

endpackage

// ===== rtl/pob_front.sv =====
// front end: takes command transfers, decodes them and queues them for the book
module pob_front import pob_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [InDataW-1:0] s_axis_tdata_i,
  input  logic [InUserW-1:0] s_axis_tuser_i,
  output logic               cmd_valid_o,
  output cmd_t               cmd_o,
  input  logic               cmd_pop_i
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  cmd_t       dec;

  assign s_axis_tready_o = (cnt_q != 2'd2);
  assign push = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = mem_q[rd_ptr_q];

  always_comb begin
    dec.op    = op_e'(s_axis_tuser_i[1:0]);
    dec.side  = s_axis_tuser_i[2];
    dec.id    = s_axis_tdata_i[IdW-1:0];
    dec.price = s_axis_tdata_i[IdW+PriceW-1:IdW];
    dec.qty   = s_axis_tdata_i[IdW+PriceW+QtyW-1:IdW+PriceW];
    cnt_d = cnt_q;
    if (push && !cmd_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && cmd_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= dec;
  end

endmodule

// ===== rtl/pob_back.sv =====
// back end: the two sorted order tables, the dump and count walks and the result register
module pob_back import pob_pkg::*; #(
  parameter int unsigned SideDepth = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  cmd_t                cmd_i,
  output logic                cmd_pop_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic [OutUserW-1:0] m_axis_tuser_o,
  output logic                m_axis_tlast_o
);

  localparam int unsigned IW = $clog2(SideDepth);
  localparam int unsigned CW = $clog2(SideDepth + 1);
  localparam int unsigned KW = $clog2(MaxResults);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_DUMP  = 3'b010,
    S_COUNT = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [PriceW-1:0] price_q [2][SideDepth];
  logic [QtyW-1:0]   qty_q   [2][SideDepth];
  logic [IdW-1:0]    id_q    [2][SideDepth];
  logic [CW-1:0]     cnt_q   [2];

  logic [PriceW-1:0] price_d [SideDepth];
  logic [QtyW-1:0]   qty_d   [SideDepth];
  logic [IdW-1:0]    id_d    [SideDepth];

  logic              sel;
  logic [CW-1:0]     n_sel;
  logic [SideDepth-1:0] lt, prev_lt, match, hit;
  logic [SideDepth-1:0] bnd [2];
  logic              found;
  logic              do_write;
  logic              is_add;

  // dump walk
  logic              dside_q;
  logic [CW-1:0]     di_q;
  logic [KW-1:0]     dk_q;
  logic [LvlQtyW-1:0] acc_q;
  logic [SmallW:0]   ords_q;
  logic [IW-1:0]     didx;
  logic [LvlQtyW:0]  sum;
  logic [LvlQtyW-1:0] nq;
  logic [SmallW:0]   no;
  logic              demit;

  // count walk
  logic [CW-1:0]     cj_q;
  logic [CW-1:0]     bl_q, sl_q;

  result_t out_q, res;
  logic    ov_q, out_free, load;

  assign out_free = !ov_q || m_axis_tready_i;
  assign sel   = (state_q == S_DUMP) ? dside_q : cmd_i.side;
  assign n_sel = cnt_q[sel];

  // per-entry compares of the selected side
  always_comb begin
    for (int k = 0; k < SideDepth; k++) begin
      lt[k] = (CW'(k) < n_sel) &&
              (sel ? (price_q[sel][k] <= cmd_i.price) : (price_q[sel][k] < cmd_i.price));
      match[k] = (CW'(k) < n_sel) && (id_q[sel][k] == cmd_i.id);
    end
    prev_lt[0] = 1'b1;
    hit[0] = match[0];
    for (int k = 1; k < SideDepth; k++) begin
      prev_lt[k] = lt[k-1];
      hit[k] = hit[k-1] | match[k];
    end
    found = hit[SideDepth-1];
  end

  // level boundaries, valid entries only
  always_comb begin
    for (int s = 0; s < 2; s++) begin
      bnd[s][0] = (cnt_q[s] != '0);
      for (int k = 1; k < SideDepth; k++) begin
        bnd[s][k] = (CW'(k) < cnt_q[s]) && (price_q[s][k] != price_q[s][k-1]);
      end
    end
  end

  // new contents of the selected side for an insert or a delete
  always_comb begin
    for (int k = 0; k < SideDepth; k++) begin
      price_d[k] = price_q[sel][k];
      qty_d[k]   = qty_q[sel][k];
      id_d[k]    = id_q[sel][k];
    end
    if (is_add) begin
      for (int k = 0; k < SideDepth; k++) begin
        if (!lt[k] && prev_lt[k]) begin
          price_d[k] = cmd_i.price;
          qty_d[k]   = cmd_i.qty;
          id_d[k]    = cmd_i.id;
        end
      end
      for (int k = 1; k < SideDepth; k++) begin
        if (!lt[k] && !prev_lt[k]) begin
          price_d[k] = price_q[sel][k-1];
          qty_d[k]   = qty_q[sel][k-1];
          id_d[k]    = id_q[sel][k-1];
        end
      end
    end else begin
      for (int k = 0; k < SideDepth - 1; k++) begin
        if (hit[k]) begin
          price_d[k] = price_q[sel][k+1];
          qty_d[k]   = qty_q[sel][k+1];
          id_d[k]    = id_q[sel][k+1];
        end
      end
    end
  end

  // one order step of the dump
  always_comb begin
    didx  = IW'(di_q - CW'(1));
    sum   = {1'b0, acc_q} + (LvlQtyW+1)'(qty_q[dside_q][didx]);
    nq    = sum[LvlQtyW] ? {LvlQtyW{1'b1}} : sum[LvlQtyW-1:0];
    no    = ords_q + (SmallW+1)'(1);
    demit = bnd[dside_q][didx];
  end

  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    do_write  = 1'b0;
    is_add    = (cmd_i.op == OP_ADD);
    load      = 1'b0;
    res       = '0;
    res.last  = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_ADD, OP_REMOVE: begin
              if (out_free) begin
                cmd_pop_o = 1'b1;
                load = 1'b1;
                if (is_add) begin
                  if (n_sel == CW'(SideDepth)) begin
                    res.status = ST_FULL;
                  end else begin
                    do_write = 1'b1;
                  end
                end else if (found) begin
                  do_write = 1'b1;
                end else begin
                  res.status = ST_NOT_FOUND;
                end
              end
            end
            OP_DUMP: begin
              cmd_pop_o = 1'b1;
              state_d = S_DUMP;
            end
            OP_COUNT: begin
              cmd_pop_o = 1'b1;
              state_d = S_COUNT;
            end
            default: ;
          endcase
        end
      end
      S_DUMP: begin
        if (di_q == '0) begin
          // only reached at the start of a dump of an empty side
          if (out_free) begin
            load = 1'b1;
            res.status = ST_EMPTY;
            state_d = S_IDLE;
          end
        end else if (demit && out_free) begin
          load = 1'b1;
          res.price  = price_q[dside_q][didx];
          res.qty    = nq;
          res.orders = sat_small(no);
          res.last   = (didx == '0) || (dk_q == KW'(MaxResults - 1));
          if (res.last) state_d = S_IDLE;
        end
      end
      S_COUNT: begin
        if (cj_q == CW'(SideDepth) && out_free) begin
          load = 1'b1;
          res.bid_lvls = sat_small((SmallW+1)'(bl_q));
          res.ask_lvls = sat_small((SmallW+1)'(sl_q));
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q[0] <= '0;
      cnt_q[1] <= '0;
      ov_q <= 1'b0;
      di_q <= '0;
      dk_q <= '0;
      ords_q <= '0;
      cj_q <= '0;
      bl_q <= '0;
      sl_q <= '0;
    end else begin
      state_q <= state_d;
      if (load) ov_q <= 1'b1;
      else if (m_axis_tready_i) ov_q <= 1'b0;
      if (do_write) begin
        cnt_q[sel] <= is_add ? n_sel + CW'(1) : n_sel - CW'(1);
      end
      if (state_q == S_IDLE) begin
        di_q   <= n_sel;
        dk_q   <= '0;
        ords_q <= '0;
        cj_q   <= '0;
        bl_q   <= '0;
        sl_q   <= '0;
      end else if (state_q == S_DUMP) begin
        if (di_q != '0 && (!demit || out_free)) begin
          di_q <= di_q - CW'(1);
          if (demit) begin
            dk_q   <= dk_q + KW'(1);
            ords_q <= '0;
          end else begin
            ords_q <= no;
          end
        end
      end else if (state_q == S_COUNT) begin
        if (cj_q != CW'(SideDepth)) begin
          cj_q <= cj_q + CW'(1);
          bl_q <= bl_q + CW'(bnd[0][cj_q[IW-1:0]]);
          sl_q <= sl_q + CW'(bnd[1][cj_q[IW-1:0]]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      dside_q <= cmd_i.side;
      acc_q   <= '0;
    end else if (state_q == S_DUMP && di_q != '0 && (!demit || out_free)) begin
      acc_q <= demit ? '0 : nq;
    end
    if (do_write) begin
      for (int k = 0; k < SideDepth; k++) begin
        price_q[sel][k] <= price_d[k];
        qty_q[sel][k]   <= qty_d[k];
        id_q[sel][k]    <= id_d[k];
      end
    end
    if (load) out_q <= res;
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {2'b00, out_q.ask_lvls, out_q.bid_lvls, out_q.orders,
                            out_q.qty, out_q.price};

endmodule

// ===== rtl/price_time_order_book_core.sv =====
// Price-time order book with a buy and a sell table of SIDE_DEPTH orders each, kept sorted
// by price in shift-register cells. Add and remove pass through the command queue and the
// compare-and-shift cells, one result each. A dump gives one result per price level,
// stepping through the resting orders of the side one at a time, at most 32 results, the
// last marked by tlast; a dump of an empty side gives a single empty result. A count query
// walks both tables together and returns one result. A two-entry command queue decouples
// the input from the book; the result register holds a result until it is taken, and the
// book waits before producing the next result while it is held.
module price_time_order_book_core import pob_pkg::*; #(
  parameter int unsigned SIDE_DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // order_id, price, quantity, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // func, side
  input  logic [InUserW-1:0]  s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // level_price, level_quantity, level_orders, buy level count, sell level count, zero pad
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // status
  output logic [OutUserW-1:0] m_axis_tuser_o,
  output logic                m_axis_tlast_o
);

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  pob_front u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  pob_back #(.SideDepth(SIDE_DEPTH)) u_back (
    .clk_i,
    .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o,
    .m_axis_tlast_o
  );

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid) else $error("command popped from an empty queue");

  a_full_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> cmd_valid) else $error("input stalled with no queued command");

  a_single_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_FULL || m_axis_tuser_o == ST_NOT_FOUND)
      |-> m_axis_tlast_o) else $error("error status not marked last");

endmodule

// ===== dv/tb_price_time_order_book_core.sv =====
// self-checking testbench of the price-time order book core
module tb_price_time_order_book_core;
  import pob_pkg::*;

  localparam int unsigned Depth       = 32;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned TailCycles  = 100;
  localparam int unsigned PhaseItems  = 63;
  localparam int unsigned ResW        = $bits(result_t);

  // book mirror and queue of results still owed by the block
  class book_scoreboard;
    logic [PriceW-1:0] lvl_px  [2][Depth];
    logic [QtyW-1:0]   lvl_qty [2][Depth];
    logic [IdW-1:0]    lvl_id  [2][Depth];
    int unsigned       fill [2];
    result_t           owed [$];
    int unsigned       errors;

    function new();
      fill[0] = 0;
      fill[1] = 0;
      errors  = 0;
    endfunction

    function void report(string what, logic [ResW-1:0] got, logic [ResW-1:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
    endfunction

    function int unsigned distinct_prices(int s);
      int unsigned n;
      n = (fill[s] == 0) ? 0 : 1;
      for (int i = 1; i < fill[s]; i++)
        if (lvl_px[s][i] != lvl_px[s][i-1]) n++;
      return n;
    endfunction

    // apply an accepted command to the mirror and queue what it causes
    function void note(cmd_t c);
      result_t r;
      int s, p, i, k;
      logic [PriceW-1:0] px;
      logic [31:0] q;
      int unsigned ords;
      s = c.side;
      r = '0;
      r.last = 1'b1;
      case (c.op)
        OP_ADD: begin
          if (fill[s] >= Depth) begin
            r.status = ST_FULL;
          end else begin
            p = 0;
            // buys go ahead of equal prices, sells behind them
            while (p < fill[s] && (s == 0 ? lvl_px[s][p] < c.price
                                          : lvl_px[s][p] <= c.price)) p++;
            for (i = fill[s]; i > p; i--) begin
              lvl_px[s][i]  = lvl_px[s][i-1];
              lvl_qty[s][i] = lvl_qty[s][i-1];
              lvl_id[s][i]  = lvl_id[s][i-1];
            end
            lvl_px[s][p]  = c.price;
            lvl_qty[s][p] = c.qty;
            lvl_id[s][p]  = c.id;
            fill[s]++;
            r.status = ST_OK;
          end
          owed.push_back(r);
        end
        OP_REMOVE: begin
          p = 0;
          while (p < fill[s] && lvl_id[s][p] != c.id) p++;
          if (p >= fill[s]) begin
            r.status = ST_NOT_FOUND;
          end else begin
            for (i = p; i + 1 < fill[s]; i++) begin
              lvl_px[s][i]  = lvl_px[s][i+1];
              lvl_qty[s][i] = lvl_qty[s][i+1];
              lvl_id[s][i]  = lvl_id[s][i+1];
            end
            fill[s]--;
            r.status = ST_OK;
          end
          owed.push_back(r);
        end
        OP_DUMP: begin
          if (fill[s] == 0) begin
            r.status = ST_EMPTY;
            owed.push_back(r);
          end else begin
            i = fill[s];
            k = 0;
            while (i > 0 && k < MaxResults) begin
              px = lvl_px[s][i-1];
              q = 0;
              ords = 0;
              while (i > 0 && lvl_px[s][i-1] == px) begin
                q += lvl_qty[s][i-1];
                ords++;
                i--;
              end
              r = '0;
              r.price  = px;
              r.qty    = (q > 32'h1FFF_FFFF) ? {LvlQtyW{1'b1}} : q[LvlQtyW-1:0];
              r.orders = ords[SmallW-1:0];
              k++;
              r.last = (i == 0 || k == MaxResults);
              owed.push_back(r);
            end
          end
        end
        default: begin
          r.bid_lvls = SmallW'(distinct_prices(0));
          r.ask_lvls = SmallW'(distinct_prices(1));
          owed.push_back(r);
        end
      endcase
    endfunction

    function void check(result_t got);
      result_t want;
      if (owed.size() == 0) begin
        report("unexpected result", got, '0);
        return;
      end
      want = owed.pop_front();
      if (got.status != want.status)
        report("status", ResW'(got.status), ResW'(want.status));
      if (got.price != want.price)
        report("level_price", ResW'(got.price), ResW'(want.price));
      if (got.qty != want.qty)
        report("level_quantity", ResW'(got.qty), ResW'(want.qty));
      if (got.orders != want.orders)
        report("level_orders", ResW'(got.orders), ResW'(want.orders));
      if (got.bid_lvls != want.bid_lvls)
        report("buy level count", ResW'(got.bid_lvls), ResW'(want.bid_lvls));
      if (got.ask_lvls != want.ask_lvls)
        report("sell level count", ResW'(got.ask_lvls), ResW'(want.ask_lvls));
      if (got.last != want.last)
        report("last", ResW'(got.last), ResW'(want.last));
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic [InUserW-1:0]  s_tuser;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic [OutUserW-1:0] m_tuser;
  logic                m_tlast;

  book_scoreboard sb;
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;
  int unsigned    hold_req;
  int unsigned    hold_seen = 0;
  int unsigned    hold_left = 0;
  int unsigned    quiet_cycles = 0;
  logic [IdW-1:0] live_ids [$];

  price_time_order_book_core #(.SIDE_DEPTH(Depth)) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HoldCycles;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // input transfers feed the mirror, output transfers are checked
  always @(posedge clk) begin
    cmd_t c;
    result_t r;
    if (rst_n && s_tvalid && s_tready) begin
      c.op    = op_e'(s_tuser[1:0]);
      c.side  = s_tuser[2];
      c.id    = s_tdata[15:0];
      c.price = s_tdata[46:16];
      c.qty   = s_tdata[70:47];
      sb.note(c);
    end
    if (rst_n && m_tvalid && m_tready) begin
      r.status   = status_e'(m_tuser);
      r.price    = m_tdata[30:0];
      r.qty      = m_tdata[59:31];
      r.orders   = m_tdata[65:60];
      r.bid_lvls = m_tdata[71:66];
      r.ask_lvls = m_tdata[77:72];
      r.last     = m_tlast;
      sb.check(r);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(op_e op, logic side, logic [IdW-1:0] id,
                      logic [PriceW-1:0] px, logic [QtyW-1:0] q);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {side, op};
    s_tdata  <= {1'b0, q, px, id};
    do @(posedge clk); while (!s_tready);
    if (op == OP_ADD) live_ids.push_back(id);
  endtask

  task automatic send_random();
    int unsigned pick;
    logic [IdW-1:0] id;
    logic [PriceW-1:0] px;
    logic [QtyW-1:0] q;
    pick = $urandom_range(99);
    id = ($urandom_range(9) < 7) ? IdW'($urandom_range(40)) : IdW'($urandom);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: px = PriceW'($urandom_range(7));
      5, 6, 7:       px = PriceW'($urandom_range(200));
      default:       px = PriceW'($urandom);
    endcase
    case ($urandom_range(9))
      0:       q = '1;
      1:       q = '0;
      default: q = QtyW'($urandom);
    endcase
    if (pick < 55) begin
      send(OP_ADD, 1'($urandom_range(1)), id, px, q);
    end else if (pick < 75) begin
      if (live_ids.size() > 0 && $urandom_range(9) < 8)
        id = live_ids[$urandom_range(live_ids.size() - 1)];
      send(OP_REMOVE, 1'($urandom_range(1)), id, PriceW'($urandom), QtyW'($urandom));
    end else if (pick < 88) begin
      send(OP_DUMP, 1'($urandom_range(1)), IdW'($urandom), PriceW'($urandom),
           QtyW'($urandom));
    end else begin
      send(OP_COUNT, 1'($urandom_range(1)), IdW'($urandom), PriceW'($urandom),
           QtyW'($urandom));
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    send_idle_pct = 9;
    recv_idle_pct = 65;
    hold_req = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty book, extremes, time priority and duplicate ids
    send(OP_COUNT, 1'b0, 16'h0, '0, '0);
    send(OP_DUMP, 1'b0, 16'h0, '0, '0);
    send(OP_DUMP, 1'b1, 16'h0, '0, '0);
    send(OP_REMOVE, 1'b0, 16'd5, '0, '0);
    send(OP_ADD, 1'b0, 16'h0000, '1, '1);
    send(OP_ADD, 1'b0, 16'hFFFF, '0, '0);
    send(OP_ADD, 1'b0, 16'd7, 31'd100, 24'd1);
    send(OP_ADD, 1'b0, 16'd8, 31'd100, 24'd2);
    send(OP_ADD, 1'b1, 16'd7, 31'd100, 24'd3);
    send(OP_ADD, 1'b1, 16'd9, 31'd100, 24'd4);
    send(OP_ADD, 1'b1, 16'd7, 31'd50, 24'd5);
    send(OP_ADD, 1'b1, 16'd7, '1, '1);
    send(OP_DUMP, 1'b0, 16'h0, '0, '0);
    send(OP_DUMP, 1'b1, 16'h0, '0, '0);
    send(OP_COUNT, 1'b1, 16'h0, '0, '0);
    send(OP_REMOVE, 1'b1, 16'd7, '0, '0);
    send(OP_REMOVE, 1'b0, 16'd7, '0, '0);
    send(OP_REMOVE, 1'b0, 16'hFFFF, '0, '0);
    send(OP_REMOVE, 1'b1, 16'h1234, '0, '0);
    send(OP_DUMP, 1'b1, 16'h0, '0, '0);
    send(OP_COUNT, 1'b0, 16'h0, '0, '0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 9;  recv_idle_pct = 65; end
        1: begin send_idle_pct = 65; recv_idle_pct = 9;  end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // long receiver hold-off so the book backs up into the input
          hold_req = hold_req + 1;
        end
      endcase
      for (int n = 0; n < PhaseItems; n++) send_random();
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pob_pkg.sv
rtl/pob_front.sv
rtl/pob_back.sv
rtl/price_time_order_book_core.sv
dv/tb_price_time_order_book_core.sv
